// File: sv/assm_pkg.sv
// shared types, codes and constants for the arming safety state machine
// no dependencies; used by every module of the block
package assm_pkg;

   localparam int COUNT_WIDTH     = 16;
   localparam int SILENCE_WIDTH   = 16;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int REQ_TDATA_WIDTH = 40;
   localparam int REQ_TUSER_WIDTH = 3;
   localparam int RSP_TDATA_WIDTH = 48;
   localparam int SHOWN_COUNT_WIDTH = 16;

   typedef enum logic [2:0] {
      FUNC_ARM_CMD   = 3'd0,
      FUNC_TERMINATE = 3'd1,
      FUNC_TAKEOFF   = 3'd2,
      FUNC_LAND      = 3'd3,
      FUNC_OFFBOARD  = 3'd4,
      FUNC_STICKS    = 3'd5,
      FUNC_BATTERY   = 3'd6,
      FUNC_TICK      = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      ACK_ACCEPTED      = 2'd0,
      ACK_DENIED        = 2'd1,
      ACK_TEMP_REJECTED = 2'd2
   } ack_type;

   typedef enum logic [2:0] {
      MODE_DISARMED  = 3'b001,
      MODE_ARMED     = 3'b010,
      MODE_EMERGENCY = 3'b100
   } mode_type;

   localparam logic [1:0] ACTION_DISARM = 2'd0;
   localparam logic [1:0] ACTION_ARM    = 2'd1;

   localparam logic [1:0] MODE_CODE_DISARMED  = 2'd0;
   localparam logic [1:0] MODE_CODE_ARMED     = 2'd1;
   localparam logic [1:0] MODE_CODE_EMERGENCY = 2'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_THROTTLE_LOW   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_YAW_LIMIT      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BATT_LOW       = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BATT_CRITICAL  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BATT_DISARM_EN = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OFFBOARD_TMO   = 3'd5;

   localparam logic signed [15:0] THROTTLE_LOW_RESET = 16'sd1638;
   localparam logic [14:0] YAW_LIMIT_RESET    = 15'd13107;
   localparam logic [2:0]  BATT_LOW_RESET     = 3'd1;
   localparam logic [2:0]  BATT_CRIT_RESET    = 3'd2;
   localparam logic        BATT_DISARM_RESET  = 1'b1;
   localparam logic [15:0] OFFBOARD_TMO_RESET = 16'd5;

   typedef struct packed {
      logic signed [15:0] throttle_low_limit;
      logic [14:0]        yaw_gesture_limit;
      logic [2:0]         battery_low_level;
      logic [2:0]         battery_critical_level;
      logic               battery_disarm_enable;
      logic [15:0]        offboard_timeout_ticks;
   } cfg_type;

   typedef struct packed {
      func_type           func;
      logic [1:0]         arm_action;
      logic               safety_ok;
      logic               rate_or_attitude_mode;
      logic signed [15:0] throttle;
      logic signed [15:0] yaw;
      logic [2:0]         battery_warning;
   } item_type;

   typedef struct packed {
      mode_type                 mode;
      logic                     nav_offboard;
      logic [2:0]               last_warning;
      logic                     offboard_seen;
      logic [SILENCE_WIDTH-1:0] silence_ticks;
      logic [COUNT_WIDTH-1:0]   arm_cycles;
      logic [COUNT_WIDTH-1:0]   emergency_stops;
   } state_type;

   typedef struct packed {
      logic                         ack_valid;
      ack_type                      ack_code;
      logic [1:0]                   vehicle_mode;
      logic                         armed;
      logic                         standby;
      logic                         lockdown;
      logic                         offboard_enabled;
      logic                         failsafe;
      logic [SHOWN_COUNT_WIDTH-1:0] arm_count;
      logic [SHOWN_COUNT_WIDTH-1:0] emergency_count;
   } result_type;

endpackage

// File: sv/assm_csr.sv
// configuration registers of the arming safety state machine
// depends on assm_pkg
module assm_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [assm_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [assm_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata,
   output assm_pkg::cfg_type                      cfg
);

   assm_pkg::cfg_type cfg_ff;
   assm_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            assm_pkg::CSR_THROTTLE_LOW:   cfg_in.throttle_low_limit = $signed(csr_wdata[15:0]);
            assm_pkg::CSR_YAW_LIMIT:      cfg_in.yaw_gesture_limit = csr_wdata[14:0];
            assm_pkg::CSR_BATT_LOW:       cfg_in.battery_low_level = csr_wdata[2:0];
            assm_pkg::CSR_BATT_CRITICAL:  cfg_in.battery_critical_level = csr_wdata[2:0];
            assm_pkg::CSR_BATT_DISARM_EN: cfg_in.battery_disarm_enable = csr_wdata[0];
            assm_pkg::CSR_OFFBOARD_TMO:   cfg_in.offboard_timeout_ticks = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.throttle_low_limit     <= assm_pkg::THROTTLE_LOW_RESET;
         cfg_ff.yaw_gesture_limit      <= assm_pkg::YAW_LIMIT_RESET;
         cfg_ff.battery_low_level      <= assm_pkg::BATT_LOW_RESET;
         cfg_ff.battery_critical_level <= assm_pkg::BATT_CRIT_RESET;
         cfg_ff.battery_disarm_enable  <= assm_pkg::BATT_DISARM_RESET;
         cfg_ff.offboard_timeout_ticks <= assm_pkg::OFFBOARD_TMO_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/assm_step.sv
// next-state and status logic for one event of the arming safety state machine
// depends on assm_pkg; purely combinational
module assm_step (
   input  assm_pkg::cfg_type    cfg,
   input  assm_pkg::state_type  state,
   input  assm_pkg::item_type   item,
   output assm_pkg::state_type  state_next,
   output assm_pkg::result_type result
);

   logic               thr_low;
   logic               yaw_arm;
   logic               yaw_disarm;
   logic signed [16:0] ylim;
   logic signed [16:0] yaw_ext;
   logic [assm_pkg::COUNT_WIDTH-1:0] arm_inc;
   logic [assm_pkg::COUNT_WIDTH-1:0] emg_inc;
   logic [assm_pkg::SILENCE_WIDTH-1:0] silence_sat;
   logic [31:0] arm_wide;
   logic [31:0] emg_wide;
   assm_pkg::state_type st;
   logic                ack_valid;
   assm_pkg::ack_type   ack_code;

   assign ylim       = $signed({2'b00, cfg.yaw_gesture_limit});
   assign yaw_ext    = 17'(item.yaw);
   assign thr_low    = item.throttle < cfg.throttle_low_limit;
   assign yaw_arm    = yaw_ext > ylim;
   assign yaw_disarm = yaw_ext < -ylim;
   assign arm_inc    = state.arm_cycles + 1'b1;
   assign emg_inc    = state.emergency_stops + 1'b1;
   assign silence_sat = (state.offboard_seen && (&state.silence_ticks) == 1'b0)
                        ? state.silence_ticks + 1'b1 : state.silence_ticks;

   always_comb begin
      st        = state;
      ack_valid = 1'b0;
      ack_code  = assm_pkg::ACK_ACCEPTED;
      unique case (item.func)
         assm_pkg::FUNC_ARM_CMD: begin
            ack_valid = 1'b1;
            if (item.arm_action == assm_pkg::ACTION_ARM) begin
               if (state.mode == assm_pkg::MODE_DISARMED) begin
                  if (item.safety_ok) begin
                     st.mode       = assm_pkg::MODE_ARMED;
                     st.arm_cycles = arm_inc;
                  end else begin
                     ack_code = assm_pkg::ACK_TEMP_REJECTED;
                  end
               end else begin
                  ack_code = assm_pkg::ACK_DENIED;
               end
            end else if (item.arm_action == assm_pkg::ACTION_DISARM) begin
               if (state.mode == assm_pkg::MODE_DISARMED) begin
                  ack_code = assm_pkg::ACK_DENIED;
               end else begin
                  st.mode = assm_pkg::MODE_DISARMED;
               end
            end else begin
               ack_code = assm_pkg::ACK_DENIED;
            end
         end
         assm_pkg::FUNC_TERMINATE: begin
            st.mode            = assm_pkg::MODE_EMERGENCY;
            st.emergency_stops = emg_inc;
         end
         assm_pkg::FUNC_TAKEOFF: begin
            ack_valid = 1'b1;
            if (state.mode == assm_pkg::MODE_ARMED) begin
               st.nav_offboard = 1'b1;
            end else begin
               ack_code = assm_pkg::ACK_DENIED;
            end
         end
         assm_pkg::FUNC_LAND: begin
            ack_valid       = 1'b1;
            st.nav_offboard = 1'b0;
         end
         assm_pkg::FUNC_OFFBOARD: begin
            st.offboard_seen = 1'b1;
            st.silence_ticks = '0;
            if (state.mode == assm_pkg::MODE_DISARMED && item.rate_or_attitude_mode
                && item.safety_ok) begin
               st.mode       = assm_pkg::MODE_ARMED;
               st.arm_cycles = arm_inc;
            end
         end
         assm_pkg::FUNC_STICKS: begin
            if (state.mode == assm_pkg::MODE_DISARMED && thr_low && yaw_arm) begin
               if (item.safety_ok) begin
                  st.mode       = assm_pkg::MODE_ARMED;
                  st.arm_cycles = arm_inc;
               end
            end else if (state.mode == assm_pkg::MODE_ARMED && thr_low && yaw_disarm) begin
               st.mode = assm_pkg::MODE_DISARMED;
            end
         end
         assm_pkg::FUNC_BATTERY: begin
            st.last_warning = item.battery_warning;
            if (cfg.battery_disarm_enable && state.mode == assm_pkg::MODE_ARMED) begin
               if (item.battery_warning >= cfg.battery_critical_level) begin
                  st.mode            = assm_pkg::MODE_EMERGENCY;
                  st.emergency_stops = emg_inc;
               end else if (item.battery_warning >= cfg.battery_low_level) begin
                  st.mode = assm_pkg::MODE_DISARMED;
               end
            end
         end
         assm_pkg::FUNC_TICK: begin
            st.silence_ticks = silence_sat;
            if (state.mode == assm_pkg::MODE_ARMED && state.offboard_seen
                && silence_sat > cfg.offboard_timeout_ticks) begin
               st.mode          = assm_pkg::MODE_DISARMED;
               st.offboard_seen = 1'b0;
               st.silence_ticks = '0;
            end
         end
         default: ;
      endcase
   end

   assign arm_wide = 32'(st.arm_cycles);
   assign emg_wide = 32'(st.emergency_stops);

   always_comb begin
      result.ack_valid        = ack_valid;
      result.ack_code         = ack_code;
      result.armed            = st.mode == assm_pkg::MODE_ARMED;
      result.standby          = st.mode == assm_pkg::MODE_DISARMED;
      result.lockdown         = st.mode == assm_pkg::MODE_EMERGENCY;
      result.offboard_enabled = st.nav_offboard;
      result.failsafe         = st.last_warning >= cfg.battery_low_level;
      result.arm_count        = arm_wide[assm_pkg::SHOWN_COUNT_WIDTH-1:0];
      result.emergency_count  = emg_wide[assm_pkg::SHOWN_COUNT_WIDTH-1:0];
      unique case (st.mode)
         assm_pkg::MODE_ARMED:     result.vehicle_mode = assm_pkg::MODE_CODE_ARMED;
         assm_pkg::MODE_EMERGENCY: result.vehicle_mode = assm_pkg::MODE_CODE_EMERGENCY;
         default:                  result.vehicle_mode = assm_pkg::MODE_CODE_DISARMED;
      endcase
   end

   assign state_next = st;

endmodule

// File: sv/arming_safety_state_machine_unit.sv
// arming safety state machine: input register, vehicle state, result register
// depends on assm_pkg, assm_csr and assm_step
// a transaction is taken into the input register, then moves through the step logic into the result register
// throughput: one transaction per cycle while the result register is free or being read (rsp_tready)
// the input stage keeps accepting while a result waits, as long as the stage is free
// synchronous reset clears state, counters and handshake flags and loads the configuration defaults
module arming_safety_state_machine_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [1:0] arm_action, [2] safety_ok, [3] rate_or_attitude_mode,
   // [19:4] throttle, [35:20] yaw, [38:36] battery_warning, [39] zero
   input  logic [assm_pkg::REQ_TDATA_WIDTH-1:0]  req_tdata,
   // [2:0] func
   input  logic [assm_pkg::REQ_TUSER_WIDTH-1:0]  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [0] ack_valid, [2:1] ack_code, [4:3] vehicle_mode, [5] armed, [6] standby,
   // [7] lockdown, [8] offboard_enabled, [9] failsafe, [25:10] arm_count,
   // [41:26] emergency_count, [47:42] zero
   output logic [assm_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata,
   input  logic                                  csr_we,
   input  logic [assm_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [assm_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   assm_pkg::cfg_type    cfg;
   assm_pkg::item_type   req_item;
   assm_pkg::item_type   item_ff;
   logic                 item_valid_ff;
   assm_pkg::state_type  state_ff;
   assm_pkg::state_type  state_in;
   assm_pkg::result_type result_in;
   assm_pkg::result_type result_ff;
   logic                 result_valid_ff;
   logic                 advance;

   assm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assm_step u_step (
      .cfg        (cfg),
      .state      (state_ff),
      .item       (item_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   always_comb begin
      req_item.func                  = assm_pkg::func_type'(req_tuser);
      req_item.arm_action            = req_tdata[1:0];
      req_item.safety_ok             = req_tdata[2];
      req_item.rate_or_attitude_mode = req_tdata[3];
      req_item.throttle              = $signed(req_tdata[19:4]);
      req_item.yaw                   = $signed(req_tdata[35:20]);
      req_item.battery_warning       = req_tdata[38:36];
   end

   assign advance    = item_valid_ff && (!result_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode            <= assm_pkg::MODE_DISARMED;
         state_ff.nav_offboard    <= 1'b0;
         state_ff.last_warning    <= '0;
         state_ff.offboard_seen   <= 1'b0;
         state_ff.silence_ticks   <= '0;
         state_ff.arm_cycles      <= '0;
         state_ff.emergency_stops <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         result_valid_ff <= 1'b0;
      end else if (advance) begin
         result_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         result_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = result_valid_ff;
   assign rsp_tdata  = {6'b000000,
                        result_ff.emergency_count,
                        result_ff.arm_count,
                        result_ff.failsafe,
                        result_ff.offboard_enabled,
                        result_ff.lockdown,
                        result_ff.standby,
                        result_ff.armed,
                        result_ff.vehicle_mode,
                        result_ff.ack_code,
                        result_ff.ack_valid};

   a_ready_when_out_free: assert property (@(posedge clock) disable iff (reset)
      !result_valid_ff |-> req_tready)
      else $error("input stalled while result register empty");

   a_arm_count_needs_arm: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && state_ff.arm_cycles != $past(state_ff.arm_cycles))
      |-> state_ff.mode == assm_pkg::MODE_ARMED)
      else $error("arm count moved without arming");

   a_emg_count_needs_emg: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && state_ff.emergency_stops != $past(state_ff.emergency_stops))
      |-> state_ff.mode == assm_pkg::MODE_EMERGENCY)
      else $error("emergency count moved without emergency");

   a_terminate_emergency: assert property (@(posedge clock) disable iff (reset)
      (advance && item_ff.func == assm_pkg::FUNC_TERMINATE)
      |=> state_ff.mode == assm_pkg::MODE_EMERGENCY)
      else $error("terminate did not enter emergency");

   a_silence_needs_seen: assert property (@(posedge clock) disable iff (reset)
      state_ff.silence_ticks != '0 |-> state_ff.offboard_seen)
      else $error("silence counting without offboard traffic");

endmodule

// File: sim/arming_safety_state_machine_unit_test.sv
// testbench for arming_safety_state_machine_unit: a directed table of events, then random ones
// every result is checked, against the fixed status of a typed directed row or else an in-bench model
// depends on assm_pkg and the unit under test only
module arming_safety_state_machine_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 150;
   localparam int SEGMENTS     = 8;
   localparam int SEGMENT_SIZE = 116;

   localparam logic [1:0] ACTION_BAD_LOW  = 2'd2;
   localparam logic [1:0] ACTION_BAD_HIGH = 2'd3;

   typedef struct {
      assm_pkg::item_type   ev;
      logic                 typed;
      assm_pkg::result_type want;
   } stim_row_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   logic [assm_pkg::REQ_TDATA_WIDTH-1:0] req_tdata = '0;
   logic [assm_pkg::REQ_TUSER_WIDTH-1:0] req_tuser = '0;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   logic [assm_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata;
   logic                                 csr_we = 1'b0;
   logic [assm_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [assm_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   // interlock model state
   assm_pkg::cfg_type limits = '{assm_pkg::THROTTLE_LOW_RESET, assm_pkg::YAW_LIMIT_RESET,
                                 assm_pkg::BATT_LOW_RESET, assm_pkg::BATT_CRIT_RESET,
                                 assm_pkg::BATT_DISARM_RESET, assm_pkg::OFFBOARD_TMO_RESET};
   logic [1:0]       veh_mode = assm_pkg::MODE_CODE_DISARMED;
   logic             nav_offboard = 1'b0;
   logic [2:0]       last_warning = 3'd0;
   logic             offboard_seen = 1'b0;
   logic [15:0]      silence_ticks = 16'd0;
   logic [15:0]      arm_cycles = 16'd0;
   logic [15:0]      emergency_stops = 16'd0;

   assm_pkg::result_type status_expected[$];
   int         mismatches = 0;
   int         tx_idle_pct = 0;
   int         rx_idle_pct = 0;
   int         hold_requests = 0;
   int         holds_served = 0;
   int         hold_left = 0;

   arming_safety_state_machine_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic assm_pkg::result_type status(input logic ack_valid,
                                                   input assm_pkg::ack_type code,
                                                   input logic [1:0] mode_code,
                                                   input logic nav, input logic fs,
                                                   input logic [15:0] arms,
                                                   input logic [15:0] emergencies);
      assm_pkg::result_type r;
      r = '0;
      r.ack_valid        = ack_valid;
      r.ack_code         = code;
      r.vehicle_mode     = mode_code;
      r.armed            = (mode_code == assm_pkg::MODE_CODE_ARMED);
      r.standby          = (mode_code == assm_pkg::MODE_CODE_DISARMED);
      r.lockdown         = (mode_code == assm_pkg::MODE_CODE_EMERGENCY);
      r.offboard_enabled = nav;
      r.failsafe         = fs;
      r.arm_count        = arms;
      r.emergency_count  = emergencies;
      return r;
   endfunction

   function automatic void arm_vehicle();
      veh_mode   = assm_pkg::MODE_CODE_ARMED;
      arm_cycles = arm_cycles + 16'd1;
   endfunction

   function automatic void enter_emergency();
      veh_mode        = assm_pkg::MODE_CODE_EMERGENCY;
      emergency_stops = emergency_stops + 16'd1;
   endfunction

   function automatic assm_pkg::result_type apply_event(input assm_pkg::item_type ev);
      logic               ack_valid;
      assm_pkg::ack_type  code;
      logic signed [16:0] ylim;
      logic               low_throttle;
      ack_valid    = 1'b0;
      code         = assm_pkg::ACK_ACCEPTED;
      ylim         = $signed({2'b00, limits.yaw_gesture_limit});
      low_throttle = $signed(ev.throttle) < $signed(limits.throttle_low_limit);
      case (ev.func)
         assm_pkg::FUNC_ARM_CMD: begin
            ack_valid = 1'b1;
            if (ev.arm_action == assm_pkg::ACTION_ARM) begin
               if (veh_mode != assm_pkg::MODE_CODE_DISARMED) begin
                  code = assm_pkg::ACK_DENIED;
               end else if (ev.safety_ok) begin
                  arm_vehicle();
               end else begin
                  code = assm_pkg::ACK_TEMP_REJECTED;
               end
            end else if (ev.arm_action == assm_pkg::ACTION_DISARM &&
                         veh_mode != assm_pkg::MODE_CODE_DISARMED) begin
               veh_mode = assm_pkg::MODE_CODE_DISARMED;
            end else begin
               code = assm_pkg::ACK_DENIED;
            end
         end
         assm_pkg::FUNC_TERMINATE: enter_emergency();
         assm_pkg::FUNC_TAKEOFF: begin
            ack_valid = 1'b1;
            if (veh_mode == assm_pkg::MODE_CODE_ARMED) begin
               nav_offboard = 1'b1;
            end else begin
               code = assm_pkg::ACK_DENIED;
            end
         end
         assm_pkg::FUNC_LAND: begin
            ack_valid    = 1'b1;
            nav_offboard = 1'b0;
         end
         assm_pkg::FUNC_OFFBOARD: begin
            offboard_seen = 1'b1;
            silence_ticks = 16'd0;
            if (veh_mode == assm_pkg::MODE_CODE_DISARMED && ev.rate_or_attitude_mode &&
                ev.safety_ok)
               arm_vehicle();
         end
         assm_pkg::FUNC_STICKS: begin
            if (veh_mode == assm_pkg::MODE_CODE_DISARMED && low_throttle &&
                $signed(ev.yaw) > ylim) begin
               if (ev.safety_ok) arm_vehicle();
            end else if (veh_mode == assm_pkg::MODE_CODE_ARMED && low_throttle &&
                         $signed(ev.yaw) < -ylim) begin
               veh_mode = assm_pkg::MODE_CODE_DISARMED;
            end
         end
         assm_pkg::FUNC_BATTERY: begin
            last_warning = ev.battery_warning;
            if (limits.battery_disarm_enable && veh_mode == assm_pkg::MODE_CODE_ARMED) begin
               if (ev.battery_warning >= limits.battery_critical_level)
                  enter_emergency();
               else if (ev.battery_warning >= limits.battery_low_level)
                  veh_mode = assm_pkg::MODE_CODE_DISARMED;
            end
         end
         default: begin
            if (offboard_seen && silence_ticks != 16'hFFFF)
               silence_ticks = silence_ticks + 16'd1;
            if (veh_mode == assm_pkg::MODE_CODE_ARMED && offboard_seen &&
                silence_ticks > limits.offboard_timeout_ticks) begin
               veh_mode      = assm_pkg::MODE_CODE_DISARMED;
               offboard_seen = 1'b0;
               silence_ticks = 16'd0;
            end
         end
      endcase
      return status(ack_valid, code, veh_mode, nav_offboard,
                    last_warning >= limits.battery_low_level, arm_cycles, emergency_stops);
   endfunction

   function automatic logic [assm_pkg::REQ_TDATA_WIDTH-1:0] pack_req(
      input assm_pkg::item_type ev);
      return {1'b0, ev.battery_warning, ev.yaw, ev.throttle, ev.rate_or_attitude_mode,
              ev.safety_ok, ev.arm_action};
   endfunction

   function automatic assm_pkg::result_type from_bus(
      input logic [assm_pkg::RSP_TDATA_WIDTH-1:0] d);
      assm_pkg::result_type r;
      r = '0;
      r.ack_valid        = d[0];
      r.ack_code         = assm_pkg::ack_type'(d[2:1]);
      r.vehicle_mode     = d[4:3];
      r.armed            = d[5];
      r.standby          = d[6];
      r.lockdown         = d[7];
      r.offboard_enabled = d[8];
      r.failsafe         = d[9];
      r.arm_count        = d[25:10];
      r.emergency_count  = d[41:26];
      return r;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s expected %0d got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   function automatic void compare_status(input assm_pkg::result_type want,
                                          input assm_pkg::result_type got);
      check_field("ack_valid", want.ack_valid, got.ack_valid);
      check_field("ack_code", want.ack_code, got.ack_code);
      check_field("vehicle_mode", want.vehicle_mode, got.vehicle_mode);
      check_field("armed", want.armed, got.armed);
      check_field("standby", want.standby, got.standby);
      check_field("lockdown", want.lockdown, got.lockdown);
      check_field("offboard_enabled", want.offboard_enabled, got.offboard_enabled);
      check_field("failsafe", want.failsafe, got.failsafe);
      check_field("arm_count", want.arm_count, got.arm_count);
      check_field("emergency_count", want.emergency_count, got.emergency_count);
   endfunction

   function automatic stim_row_type row(input assm_pkg::func_type f, input logic [1:0] act,
                                        input logic safe, input logic rate,
                                        input logic [15:0] thr, input logic [15:0] yaw,
                                        input logic [2:0] warn);
      stim_row_type s;
      s.ev.func                  = f;
      s.ev.arm_action            = act;
      s.ev.safety_ok             = safe;
      s.ev.rate_or_attitude_mode = rate;
      s.ev.throttle              = thr;
      s.ev.yaw                   = yaw;
      s.ev.battery_warning       = warn;
      s.typed                    = 1'b0;
      s.want                     = '0;
      return s;
   endfunction

   function automatic stim_row_type known(input stim_row_type s,
                                          input assm_pkg::result_type want);
      s.typed = 1'b1;
      s.want  = want;
      return s;
   endfunction

   function automatic assm_pkg::item_type random_event();
      assm_pkg::item_type ev;
      int unsigned pick;
      logic [15:0] ylim;
      logic [15:0] mag;
      ylim = {1'b0, limits.yaw_gesture_limit};
      pick = $urandom_range(0, 99);
      if (pick < 18)      ev.func = assm_pkg::FUNC_ARM_CMD;
      else if (pick < 21) ev.func = assm_pkg::FUNC_TERMINATE;
      else if (pick < 29) ev.func = assm_pkg::FUNC_TAKEOFF;
      else if (pick < 35) ev.func = assm_pkg::FUNC_LAND;
      else if (pick < 47) ev.func = assm_pkg::FUNC_OFFBOARD;
      else if (pick < 69) ev.func = assm_pkg::FUNC_STICKS;
      else if (pick < 79) ev.func = assm_pkg::FUNC_BATTERY;
      else                ev.func = assm_pkg::FUNC_TICK;
      pick = $urandom_range(0, 9);
      if (pick < 4)       ev.arm_action = assm_pkg::ACTION_ARM;
      else if (pick < 8)  ev.arm_action = assm_pkg::ACTION_DISARM;
      else if (pick == 8) ev.arm_action = ACTION_BAD_LOW;
      else                ev.arm_action = ACTION_BAD_HIGH;
      ev.safety_ok             = ($urandom_range(0, 4) != 0);
      ev.rate_or_attitude_mode = 1'($urandom_range(0, 1));
      // steer the sticks around the gesture thresholds most of the time
      case ($urandom_range(0, 3))
         0:       ev.throttle = 16'($urandom);
         1:       ev.throttle = 16'(limits.throttle_low_limit + $urandom_range(0, 4) - 2);
         default: ev.throttle = 16'(limits.throttle_low_limit - $urandom_range(1, 2000));
      endcase
      mag = 16'(ylim + $urandom_range(1, 2000));
      case ($urandom_range(0, 3))
         0: ev.yaw = 16'($urandom);
         1: ev.yaw = 16'(ylim + $urandom_range(0, 4) - 2);
         2: ev.yaw = 16'(16'd0 - ylim + $urandom_range(0, 4) - 2);
         default: ev.yaw = $urandom_range(0, 1) ? mag : 16'(16'd0 - mag);
      endcase
      ev.battery_warning = $urandom_range(0, 1) ? 3'($urandom) : 3'd0;
      return ev;
   endfunction

   task automatic offer(input assm_pkg::item_type ev, input logic typed,
                        input assm_pkg::result_type want);
      assm_pkg::result_type predicted;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pack_req(ev);
      req_tuser  <= ev.func;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = apply_event(ev);
      status_expected.push_back(typed ? want : predicted);
   endtask

   task automatic write_reg(input logic [assm_pkg::CSR_INDEX_WIDTH-1:0] index,
                            input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         assm_pkg::CSR_THROTTLE_LOW:   limits.throttle_low_limit     = value;
         assm_pkg::CSR_YAW_LIMIT:      limits.yaw_gesture_limit      = value[14:0];
         assm_pkg::CSR_BATT_LOW:       limits.battery_low_level      = value[2:0];
         assm_pkg::CSR_BATT_CRITICAL:  limits.battery_critical_level = value[2:0];
         assm_pkg::CSR_BATT_DISARM_EN: limits.battery_disarm_enable  = value[0];
         assm_pkg::CSR_OFFBOARD_TMO:   limits.offboard_timeout_ticks = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // unused upper bits of the write data carry noise
   task automatic load_settings(input logic [15:0] thr, input logic [14:0] yaw,
                                input logic [2:0] low, input logic [2:0] crit,
                                input logic en, input logic [15:0] tmo);
      write_reg(assm_pkg::CSR_THROTTLE_LOW, thr);
      write_reg(assm_pkg::CSR_YAW_LIMIT, {1'($urandom_range(0, 1)), yaw});
      write_reg(assm_pkg::CSR_BATT_LOW, {13'($urandom), low});
      write_reg(assm_pkg::CSR_BATT_CRITICAL, {13'($urandom), crit});
      write_reg(assm_pkg::CSR_BATT_DISARM_EN, {15'($urandom), en});
      write_reg(assm_pkg::CSR_OFFBOARD_TMO, tmo);
      csr_we <= 1'b0;
   endtask

   // result side: check each transaction, stall at random or for a long hold
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (status_expected.size() == 0) begin
            $error("unexpected result transaction %h", rsp_tdata);
            mismatches++;
         end else begin
            compare_status(status_expected.pop_front(), from_bus(rsp_tdata));
         end
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (holds_served < hold_requests) begin
         rsp_tready   <= 1'b0;
         hold_left    <= HOLD_CYCLES;
         holds_served <= holds_served + 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            quiet = 0;
         else
            quiet++;
      end
      $display("arming_safety_state_machine_unit_test NOT OK");
      $finish;
   end

   initial begin
      stim_row_type directed_rows[$];
      directed_rows.push_back(known(
         row(assm_pkg::FUNC_ARM_CMD, assm_pkg::ACTION_ARM, 1'b0, 1'b0, 16'h0, 16'h0, 3'd0),
         status(1'b1, assm_pkg::ACK_TEMP_REJECTED, assm_pkg::MODE_CODE_DISARMED,
                1'b0, 1'b0, 16'd0, 16'd0)));
      directed_rows.push_back(known(
         row(assm_pkg::FUNC_ARM_CMD, assm_pkg::ACTION_DISARM, 1'b1, 1'b1, 16'h0, 16'h0, 3'd0),
         status(1'b1, assm_pkg::ACK_DENIED, assm_pkg::MODE_CODE_DISARMED,
                1'b0, 1'b0, 16'd0, 16'd0)));
      directed_rows.push_back(known(
         row(assm_pkg::FUNC_ARM_CMD, ACTION_BAD_LOW, 1'b1, 1'b0, 16'h0, 16'h0, 3'd0),
         status(1'b1, assm_pkg::ACK_DENIED, assm_pkg::MODE_CODE_DISARMED,
                1'b0, 1'b0, 16'd0, 16'd0)));
      directed_rows.push_back(known(
         row(assm_pkg::FUNC_ARM_CMD, ACTION_BAD_HIGH, 1'b1, 1'b0, 16'h0, 16'h0, 3'd0),
         status(1'b1, assm_pkg::ACK_DENIED, assm_pkg::MODE_CODE_DISARMED,
                1'b0, 1'b0, 16'd0, 16'd0)));
      directed_rows.push_back(known(
         row(assm_pkg::FUNC_TAKEOFF, assm_pkg::ACTION_ARM, 1'b1, 1'b0, 16'h0, 16'h0, 3'd0),
         status(1'b1, assm_pkg::ACK_DENIED, assm_pkg::MODE_CODE_DISARMED,
                1'b0, 1'b0, 16'd0, 16'd0)));
      directed_rows.push_back(known(
         row(assm_pkg::FUNC_LAND, assm_pkg::ACTION_ARM, 1'b1, 1'b0, 16'h0, 16'h0, 3'd0),
         status(1'b1, assm_pkg::ACK_ACCEPTED, assm_pkg::MODE_CODE_DISARMED,
                1'b0, 1'b0, 16'd0, 16'd0)));
      directed_rows.push_back(known(
         row(assm_pkg::FUNC_ARM_CMD, assm_pkg::ACTION_ARM, 1'b1, 1'b0, 16'h0, 16'h0, 3'd0),
         status(1'b1, assm_pkg::ACK_ACCEPTED, assm_pkg::MODE_CODE_ARMED,
                1'b0, 1'b0, 16'd1, 16'd0)));
      directed_rows.push_back(known(
         row(assm_pkg::FUNC_ARM_CMD, assm_pkg::ACTION_ARM, 1'b1, 1'b0, 16'h0, 16'h0, 3'd0),
         status(1'b1, assm_pkg::ACK_DENIED, assm_pkg::MODE_CODE_ARMED,
                1'b0, 1'b0, 16'd1, 16'd0)));
      directed_rows.push_back(row(assm_pkg::FUNC_TAKEOFF, assm_pkg::ACTION_ARM, 1'b1, 1'b0,
                                  16'h0, 16'h0, 3'd0));
      directed_rows.push_back(row(assm_pkg::FUNC_STICKS, assm_pkg::ACTION_ARM, 1'b1, 1'b0,
                                  16'h8000, 16'h8000, 3'd0));
      directed_rows.push_back(row(assm_pkg::FUNC_STICKS, assm_pkg::ACTION_ARM, 1'b0, 1'b0,
                                  16'h8000, 16'h7FFF, 3'd0));
      directed_rows.push_back(row(assm_pkg::FUNC_STICKS, assm_pkg::ACTION_ARM, 1'b1, 1'b0,
                                  16'd1637, 16'd13108, 3'd0));
      directed_rows.push_back(row(assm_pkg::FUNC_STICKS, assm_pkg::ACTION_ARM, 1'b1, 1'b0,
                                  16'd1638, -16'sd13108, 3'd0));
      directed_rows.push_back(row(assm_pkg::FUNC_STICKS, assm_pkg::ACTION_ARM, 1'b1, 1'b0,
                                  16'd1637, -16'sd13107, 3'd0));
      directed_rows.push_back(row(assm_pkg::FUNC_BATTERY, assm_pkg::ACTION_ARM, 1'b1, 1'b0,
                                  16'h0, 16'h0, 3'd7));
      directed_rows.push_back(row(assm_pkg::FUNC_TERMINATE, assm_pkg::ACTION_ARM, 1'b1, 1'b1,
                                  16'hFFFF, 16'hFFFF, 3'd7));
      directed_rows.push_back(row(assm_pkg::FUNC_ARM_CMD, assm_pkg::ACTION_DISARM, 1'b0, 1'b0,
                                  16'h0, 16'h0, 3'd0));
      directed_rows.push_back(row(assm_pkg::FUNC_OFFBOARD, assm_pkg::ACTION_DISARM, 1'b1, 1'b1,
                                  16'h0, 16'h0, 3'd0));
      repeat (6) directed_rows.push_back(row(assm_pkg::FUNC_TICK, assm_pkg::ACTION_DISARM,
                                             1'b0, 1'b0, 16'h0, 16'h0, 3'd0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      tx_idle_pct = 18;
      rx_idle_pct = 78;
      foreach (directed_rows[i])
         offer(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         // settings change only once the block has drained
         req_tvalid <= 1'b0;
         while (status_expected.size() != 0) @(posedge clock);
         case (seg)
            0: load_settings(assm_pkg::THROTTLE_LOW_RESET, assm_pkg::YAW_LIMIT_RESET,
                             assm_pkg::BATT_LOW_RESET, assm_pkg::BATT_CRIT_RESET,
                             assm_pkg::BATT_DISARM_RESET, assm_pkg::OFFBOARD_TMO_RESET);
            1: load_settings(16'h8000, 15'd0, 3'd0, 3'd0, 1'b1, 16'd0);
            2: load_settings(16'h7FFF, 15'h7FFF, 3'd7, 3'd7, 1'b1, 16'hFFFF);
            3: load_settings(16'($urandom_range(0, 16384)), 15'($urandom_range(4000, 16000)),
                             3'($urandom), 3'($urandom), 1'b0, 16'($urandom_range(0, 10)));
            4: load_settings(assm_pkg::THROTTLE_LOW_RESET, assm_pkg::YAW_LIMIT_RESET,
                             3'd3, 3'd5, 1'b1, 16'd2);
            5: load_settings(16'd0, 15'd16384, 3'd2, 3'd1, 1'b0, 16'hFFFE);
            6: load_settings(16'($urandom_range(0, 20000) - 4000),
                             15'($urandom_range(2000, 20000)), 3'($urandom), 3'($urandom),
                             1'b1, 16'($urandom_range(0, 6)));
            default: load_settings(16'hFFFF, 15'd1, 3'd1, 3'd3, 1'b1, 16'd8);
         endcase
         if (seg < 3) begin
            tx_idle_pct = 18;
            rx_idle_pct = 78;
         end else if (seg < 6) begin
            tx_idle_pct = 78;
            rx_idle_pct = 18;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         if (seg == 3 || seg == 6) hold_requests++;
         repeat (SEGMENT_SIZE) offer(random_event(), 1'b0, '0);
      end

      req_tvalid <= 1'b0;
      while (status_expected.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && status_expected.size() == 0)
         $display("arming_safety_state_machine_unit_test OK");
      else
         $display("arming_safety_state_machine_unit_test NOT OK");
      $finish;
   end

endmodule

// File: files.f
sv/assm_pkg.sv
sv/assm_csr.sv
sv/assm_step.sv
sv/arming_safety_state_machine_unit.sv
sim/arming_safety_state_machine_unit_test.sv
